// ----- rtl/tcpwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpwm_pkg
// Types, codes and constants shared by the two-channel PWM generator.
// ----------------------------------------------------------------------------
package tcpwm_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int TICK_W       = 15;

  typedef logic [TICK_W-1:0] tick_t;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_DUTY    = 3'd1;
  localparam logic [2:0] MODE_TICKS   = 3'd2;
  localparam logic [2:0] MODE_OFF     = 3'd3;
  localparam logic [2:0] MODE_ALL_OFF = 3'd4;

  localparam int    PCT_FULL     = 100;
  localparam tick_t FORCED_ON    = tick_t'(2);
  localparam tick_t PERIOD_RESET = tick_t'(327);

  // period split as hund * 100 + rem, so duty * period / 100 stays narrow
  localparam logic [8:0] HUND_RESET = 9'(327 / PCT_FULL);
  localparam logic [6:0] REM_RESET  = 7'(327 % PCT_FULL);

  // exact reciprocals of 100: x < 2^15 uses >> 22, x < 2^14 uses >> 21
  localparam logic [15:0] RECIP_CFG = 16'd41944;
  localparam logic [14:0] RECIP_REM = 15'd20972;

  typedef struct packed {
    logic [2:0]  mode;
    logic        channel;
    logic [2:0]  pin;
    logic [6:0]  duty_percent;
    logic [15:0] pulse_ticks;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  port_out;
    tick_t       on_time;
    logic        accepted;
    logic        period_start;
  } out_item_t;

  typedef struct packed {
    tick_t      period;
    logic [8:0] hund;
    logic [6:0] rem;
  } cfg_t;

  typedef struct packed {
    in_item_t    item;
    logic [15:0] prod_hund;   // duty * (period / 100)
    logic [13:0] prod_rem;    // duty * (period % 100)
  } stage_t;

endpackage

// ----- rtl/two_channel_pwm_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_pwm_generator_top
// Two PWM channels on a shared up-counter, driven by tick and command items.
// ----------------------------------------------------------------------------
//   port group   dir   handshake             payload
//   in_          in    in_valid / in_stall   in_data   (tcpwm_pkg::in_item_t)
//   out_         out   out_valid / out_stall out_data  (tcpwm_pkg::out_item_t)
//   cfg_         in    cfg_we                cfg_wdata (period, 15 bits)
//
// One item per cycle while out_stall is low; each item gives one result after
// its transfer, through the input register, then the result register.
// All channel state is updated in one pass per item, set by the shared counter.
// rst_n is synchronous: state cleared, period back to 327.
// A stalled result holds; the input register keeps taking items until it too
// is full, then in_stall rises.
// ----------------------------------------------------------------------------
module two_channel_pwm_generator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcpwm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcpwm_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  tcpwm_pkg::tick_t     cfg_wdata
);
  import tcpwm_pkg::*;

  cfg_t   cfg;
  logic   hold;
  logic   s1_valid;
  stage_t s1_data;

  tcpwm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tcpwm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .hold     (hold),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  tcpwm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/tcpwm_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpwm_cfg
// Period register, kept together with its quotient and remainder by 100.
// ----------------------------------------------------------------------------
module tcpwm_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  tcpwm_pkg::tick_t cfg_wdata,
  output tcpwm_pkg::cfg_t  cfg
);
  import tcpwm_pkg::*;

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic [30:0] recip_prod;
  logic [8:0]  hund;
  tick_t       hund_x100;

  always_comb begin
    recip_prod = 31'(cfg_wdata) * 31'(RECIP_CFG);
    hund       = recip_prod[30:22];
    hund_x100  = tick_t'(hund) * tick_t'(PCT_FULL);
    cfg_nxt.period = cfg_wdata;
    cfg_nxt.hund   = hund;
    cfg_nxt.rem    = 7'(cfg_wdata - hund_x100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period <= PERIOD_RESET;
      cfg_r.hund   <= HUND_RESET;
      cfg_r.rem    <= REM_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/tcpwm_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpwm_in_stage
// Input register; also forms the two duty products for the percent command.
// ----------------------------------------------------------------------------
module tcpwm_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcpwm_pkg::in_item_t in_data,
  input  tcpwm_pkg::cfg_t     cfg,
  input  logic                hold,
  output logic                s1_valid,
  output tcpwm_pkg::stage_t   s1_data
);
  import tcpwm_pkg::*;

  logic   s1_valid_r;
  stage_t s1_data_r;
  stage_t s1_data_nxt;

  assign in_stall = s1_valid_r && hold;

  always_comb begin
    s1_data_nxt.item      = in_data;
    s1_data_nxt.prod_hund = 16'(in_data.duty_percent) * 16'(cfg.hund);
    s1_data_nxt.prod_rem  = 14'(in_data.duty_percent) * 14'(cfg.rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= s1_data_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

// ----- rtl/tcpwm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpwm_core
// Shared counter, channel state and port bits; result register.
// ----------------------------------------------------------------------------
module tcpwm_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcpwm_pkg::cfg_t      cfg,
  input  logic                 s1_valid,
  input  tcpwm_pkg::stage_t    s1_data,
  output logic                 hold,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcpwm_pkg::out_item_t out_data
);
  import tcpwm_pkg::*;

  tick_t      cnt_r;
  tick_t      cnt_nxt;
  tick_t      on_r    [NUM_CHANNELS];
  tick_t      on_nxt  [NUM_CHANNELS];
  logic [2:0] pin_r   [NUM_CHANNELS];
  logic [2:0] pin_nxt [NUM_CHANNELS];
  logic       en_r    [NUM_CHANNELS];
  logic       en_nxt  [NUM_CHANNELS];
  logic [7:0] port_r;
  logic [7:0] port_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  out_data_nxt;

  logic        adv;
  in_item_t    it;
  logic        ch_ok;
  logic        wrap;
  logic        accepted;
  logic        pulsing [NUM_CHANNELS];
  logic [28:0] rem_prod;
  logic [7:0]  rem_q;
  tick_t       on_pct;
  tick_t       on_duty;

  assign hold = out_valid_r && out_stall;
  assign adv  = s1_valid && !hold;
  assign it   = s1_data.item;

  // duty * period / 100 = duty * hund + (duty * rem) / 100
  always_comb begin
    rem_prod = 29'(s1_data.prod_rem) * 29'(RECIP_REM);
    rem_q    = rem_prod[28:21];
    on_pct   = tick_t'(16'(s1_data.prod_hund) + 16'(rem_q));
    on_duty  = (on_pct == '0 && it.duty_percent != '0) ? FORCED_ON : on_pct;
  end

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pulsing[c] = (on_r[c] != '0) && (on_r[c] != cfg.period);
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    on_nxt   = on_r;
    pin_nxt  = pin_r;
    en_nxt   = en_r;
    port_nxt = port_r;
    accepted = 1'b0;
    wrap     = 1'b0;
    ch_ok    = 32'(it.channel) < NUM_CHANNELS;

    unique case (it.mode)
      MODE_TICK: begin
        accepted = 1'b1;
        if (cnt_r >= cfg.period) begin
          wrap    = 1'b1;
          cnt_nxt = '0;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (pulsing[c]) port_nxt[pin_r[c]] = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + tick_t'(1);
        end
        // clears come after the sets of the same tick
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (en_r[c] && cnt_nxt == on_r[c] && pulsing[c]) port_nxt[pin_r[c]] = 1'b0;
        end
      end
      MODE_DUTY: begin
        if (ch_ok && 32'(it.duty_percent) <= PCT_FULL) begin
          accepted             = 1'b1;
          pin_nxt[it.channel]  = it.pin;
          if (32'(it.duty_percent) == PCT_FULL) begin
            en_nxt[it.channel] = 1'b0;
            on_nxt[it.channel] = cfg.period;
            port_nxt[it.pin]   = 1'b1;
          end else if (it.duty_percent == '0) begin
            en_nxt[it.channel] = 1'b0;
            on_nxt[it.channel] = '0;
            port_nxt[it.pin]   = 1'b0;
          end else begin
            en_nxt[it.channel] = 1'b1;
            on_nxt[it.channel] = on_duty;
          end
        end
      end
      MODE_TICKS: begin
        if (ch_ok && it.pulse_ticks != '0 && it.pulse_ticks <= 16'(cfg.period)) begin
          accepted            = 1'b1;
          en_nxt[it.channel]  = 1'b1;
          pin_nxt[it.channel] = it.pin;
          on_nxt[it.channel]  = tick_t'(it.pulse_ticks);
        end
      end
      MODE_OFF: begin
        if (ch_ok) begin
          accepted                     = 1'b1;
          en_nxt[it.channel]           = 1'b0;
          port_nxt[pin_r[it.channel]]  = 1'b0;
          on_nxt[it.channel]           = '0;
        end
      end
      MODE_ALL_OFF: begin
        accepted = 1'b1;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (on_r[c] != '0) begin
            port_nxt[pin_r[c]] = 1'b0;
            on_nxt[c]          = '0;
          end
          en_nxt[c] = 1'b0;
        end
      end
      default: ;
    endcase

    out_data_nxt.port_out     = port_nxt;
    out_data_nxt.on_time      = ch_ok ? on_nxt[it.channel] : '0;
    out_data_nxt.accepted     = accepted;
    out_data_nxt.period_start = wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      port_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        on_r[c]  <= '0;
        pin_r[c] <= '0;
        en_r[c]  <= 1'b0;
      end
    end else if (adv) begin
      cnt_r  <= cnt_nxt;
      port_r <= port_nxt;
      on_r   <= on_nxt;
      pin_r  <= pin_nxt;
      en_r   <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a wrapping tick leaves the counter at zero
  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && it.mode == MODE_TICK && wrap |=> cnt_r == '0)
    else $error("counter not zero after wrap");

  // period start only ever comes from a tick, which is always accepted
  a_start_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.period_start |-> out_data_r.accepted)
    else $error("period start on a rejected item");

  // a rejected command leaves the port bits alone
  a_reject_port: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !accepted |=> port_r == $past(port_r))
    else $error("rejected command changed port bits");

  // the result register is only refilled when its transfer has completed
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("pending result overwritten");

  // an enabled compare always has a nonzero on-time
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_en_chk
    a_en_on: assert property (@(posedge clk) disable iff (!rst_n)
      en_r[g] |-> on_r[g] != '0)
      else $error("compare enabled with zero on-time");
  end

endmodule

// ----- verif/two_channel_pwm_generator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_pwm_generator_top_tb
// Self-checking bench for the two-channel PWM generator. A scoreboard class
// keeps its own copy of the counter, channel state and port bits, predicts
// one result per input transfer and checks results in order. Stimulus is a
// short directed set, then random phases at several periods (zero and full
// scale among them) with random idling on the source and receiver sides and
// two long receiver hold-offs that back up the input.
// ----------------------------------------------------------------------------
module two_channel_pwm_generator_top_tb;
  import tcpwm_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 9;
  localparam int ITEMS_PER_PHASE = 94;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CFG_SETTLE      = 2;

  // codes beyond the last defined command are rejected by the block
  localparam logic [2:0] MODE_BAD_LO = MODE_ALL_OFF + 3'd1;
  localparam logic [2:0] MODE_BAD_HI = '1;

  localparam tick_t PHASE_PERIODS [12] = '{
    tick_t'(17), tick_t'(0), tick_t'(1), tick_t'(7), tick_t'(100), tick_t'(32767),
    tick_t'(3), tick_t'(64), tick_t'(2), tick_t'(250), tick_t'(33), tick_t'(12)
  };

  class pwm_scoreboard;
    tick_t       period;
    tick_t       count;
    tick_t       on_t   [NUM_CHANNELS];
    logic [2:0]  pin_of [NUM_CHANNELS];
    bit          cmp_en [NUM_CHANNELS];
    logic [7:0]  port;
    out_item_t   pending_results [$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_wraps;
    int          n_rejected;

    function new();
      period = PERIOD_RESET;
      count  = '0;
      port   = '0;
      foreach (on_t[c]) begin
        on_t[c]   = '0;
        pin_of[c] = '0;
        cmp_en[c] = 1'b0;
      end
    endfunction

    function bit pulsing(int c);
      return on_t[c] != '0 && on_t[c] != period;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   res;
      int          ch;
      int unsigned duty_w;
      int unsigned per_w;
      int unsigned on_calc;
      ch      = it.channel;
      duty_w  = it.duty_percent;
      per_w   = period;
      res     = '0;
      n_items++;
      case (it.mode)
        MODE_TICK: begin
          res.accepted = 1'b1;
          if (count >= period) begin
            count            = '0;
            res.period_start = 1'b1;
            n_wraps++;
            for (int c = 0; c < NUM_CHANNELS; c++)
              if (pulsing(c)) port[pin_of[c]] = 1'b1;
          end else begin
            count = count + tick_t'(1);
          end
          // both channels may clear in the same tick
          for (int c = 0; c < NUM_CHANNELS; c++)
            if (cmp_en[c] && count == on_t[c] && pulsing(c)) port[pin_of[c]] = 1'b0;
        end
        MODE_DUTY: begin
          if (ch < NUM_CHANNELS && duty_w <= PCT_FULL) begin
            on_calc = duty_w * per_w / PCT_FULL;
            if (on_calc == 0 && duty_w != 0) on_calc = FORCED_ON;
            res.accepted = 1'b1;
            pin_of[ch]   = it.pin;
            if (duty_w == PCT_FULL) begin
              cmp_en[ch]    = 1'b0;
              on_t[ch]      = period;
              port[it.pin]  = 1'b1;
            end else if (duty_w == 0) begin
              cmp_en[ch]    = 1'b0;
              on_t[ch]      = '0;
              port[it.pin]  = 1'b0;
            end else begin
              cmp_en[ch]    = 1'b1;
              on_t[ch]      = tick_t'(on_calc);
            end
          end
        end
        MODE_TICKS: begin
          if (ch < NUM_CHANNELS && it.pulse_ticks != '0 && it.pulse_ticks <= period) begin
            res.accepted = 1'b1;
            cmp_en[ch]   = 1'b1;
            pin_of[ch]   = it.pin;
            on_t[ch]     = tick_t'(it.pulse_ticks);
          end
        end
        MODE_OFF: begin
          if (ch < NUM_CHANNELS) begin
            res.accepted       = 1'b1;
            cmp_en[ch]         = 1'b0;
            port[pin_of[ch]]   = 1'b0;
            on_t[ch]           = '0;
          end
        end
        MODE_ALL_OFF: begin
          res.accepted = 1'b1;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (on_t[c] != '0) begin
              port[pin_of[c]] = 1'b0;
              on_t[c]         = '0;
            end
            cmp_en[c] = 1'b0;
          end
        end
        default: ;
      endcase
      if (!res.accepted) n_rejected++;
      res.port_out = port;
      res.on_time  = (ch < NUM_CHANNELS) ? on_t[ch] : '0;
      pending_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no transfer waiting: port_out %02h on_time %0d",
               got.port_out, got.on_time);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.port_out !== want.port_out) begin
        $error("port_out: expected %02h, got %02h", want.port_out, got.port_out);
        errors++;
      end
      if (got.on_time !== want.on_time) begin
        $error("on_time: expected %0d, got %0d", want.on_time, got.on_time);
        errors++;
      end
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
        errors++;
      end
      if (got.period_start !== want.period_start) begin
        $error("period_start: expected %0b, got %0b", want.period_start, got.period_start);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  tick_t     cfg_wdata;

  pwm_scoreboard sb = new();

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int n_holds       = 0;
  int n_cfg         = 0;
  int quiet_cycles  = 0;

  two_channel_pwm_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  function automatic in_item_t cmd(logic [2:0] mode, logic ch, logic [2:0] pin,
                                   logic [6:0] duty, logic [15:0] pulse);
    in_item_t it;
    it.mode         = mode;
    it.channel      = ch;
    it.pin          = pin;
    it.duty_percent = duty;
    it.pulse_ticks  = pulse;
    return it;
  endfunction

  // mostly ticks so the counter sweeps whole periods; commands carry
  // in-range arguments most of the time, raw field values otherwise
  function automatic in_item_t make_random_item(tick_t per);
    in_item_t it;
    int       r;
    it.mode         = MODE_TICK;
    it.channel      = 1'($urandom_range(1));
    it.pin          = 3'($urandom_range(7));
    it.duty_percent = 7'($urandom_range(127));
    it.pulse_ticks  = 16'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 64) begin
      it.mode = MODE_TICK;
    end else if (r < 76) begin
      it.mode = MODE_DUTY;
      if ($urandom_range(9) != 0) it.duty_percent = 7'($urandom_range(PCT_FULL));
    end else if (r < 86) begin
      it.mode = MODE_TICKS;
      if ($urandom_range(9) != 0) it.pulse_ticks = 16'($urandom_range(per, 1));
    end else if (r < 92) begin
      it.mode = MODE_OFF;
    end else if (r < 96) begin
      it.mode = MODE_ALL_OFF;
    end else begin
      it.mode = 3'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(it);
  endtask

  // period changes only with nothing in flight
  task automatic write_period(input tick_t value);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.period = value;
    n_cfg++;
  endtask

  task automatic set_idling(input int idle_mode);
    case (idle_mode)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
      default: begin src_idle_pct = 31; snk_stall_pct = 31; end
    endcase
  endtask

  task automatic run_directed();
    // static low, static high, rejected duties, a duty near full scale
    send_item(cmd(MODE_DUTY, 1'b0, 3'd7, 7'd0, 16'd0));
    send_item(cmd(MODE_DUTY, 1'b0, 3'd7, 7'(PCT_FULL), 16'd0));
    send_item(cmd(MODE_DUTY, 1'b1, 3'd0, 7'(PCT_FULL + 1), 16'd0));
    send_item(cmd(MODE_DUTY, 1'b1, 3'd0, '1, '1));
    send_item(cmd(MODE_DUTY, 1'b1, 3'd3, 7'd99, 16'd0));
    // on-time bounds: zero, top of field, one past period, equal to period
    send_item(cmd(MODE_TICKS, 1'b1, 3'd3, 7'd0, 16'd0));
    send_item(cmd(MODE_TICKS, 1'b1, 3'd3, 7'd0, '1));
    send_item(cmd(MODE_TICKS, 1'b1, 3'd3, 7'd0, 16'(PERIOD_RESET) + 16'd1));
    send_item(cmd(MODE_TICKS, 1'b0, 3'd5, 7'd0, 16'(PERIOD_RESET)));
    send_item(cmd(MODE_TICK, 1'b0, 3'd0, 7'd0, 16'd0));
    send_item(cmd(MODE_TICK, 1'b1, 3'd7, '1, '1));
    send_item(cmd(MODE_OFF, 1'b0, 3'd0, 7'd0, 16'd0));
    send_item(cmd(MODE_ALL_OFF, 1'b1, 3'd0, 7'd0, 16'd0));
    send_item(cmd(MODE_BAD_LO, 1'b0, 3'd1, 7'd50, 16'd5));
    send_item(cmd(MODE_BAD_LO + 3'd1, 1'b1, 3'd1, 7'd50, 16'd5));
    send_item(cmd(MODE_BAD_HI, 1'b1, 3'd1, 7'd50, 16'd5));
    // period 1: duty 1 rounds to zero, forced on-time lies past the period
    write_period(tick_t'(1));
    send_item(cmd(MODE_DUTY, 1'b0, 3'd2, 7'd1, 16'd0));
    repeat (3) send_item(cmd(MODE_TICK, 1'b0, 3'd0, 7'd0, 16'd0));
    // both channels clear on the same tick
    write_period(tick_t'(4));
    send_item(cmd(MODE_TICKS, 1'b0, 3'd4, 7'd0, 16'd2));
    send_item(cmd(MODE_TICKS, 1'b1, 3'd5, 7'd0, 16'd2));
    repeat (6) send_item(cmd(MODE_TICK, 1'b0, 3'd0, 7'd0, 16'd0));
  endtask

  // result side: check each transfer, then pick the next stall
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(out_data);
      if (n_holds < hold_req) begin
        hold_left = HOLD_CYCLES;
        n_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < $size(PHASE_PERIODS); ph++) begin
      write_period(PHASE_PERIODS[ph]);
      set_idling(ph % 4);
      // long receiver hold-off so the input side backs up
      if (ph == 2 || ph == 7) hold_req++;
      repeat (ITEMS_PER_PHASE) send_item(make_random_item(sb.period));
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("coverage: %0d transfers in, %0d results, %0d period starts, %0d rejected",
             sb.n_items, sb.n_results, sb.n_wraps, sb.n_rejected);
    $display("coverage: %0d period settings, %0d long hold-offs, %0d mismatches",
             n_cfg, n_holds, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
